@@ design/hbs_pkg.sv @@
// ----------------------------------------------------------------------------
// hbs_pkg: shared types and constants for the heightmap bilinear sampler
// Fixed field widths, command and register codes, store request bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package hbs_pkg;

	// fixed field widths
	localparam int CFG_DATA_W  = 9;
	localparam int CFG_IDX_W   = 1;
	localparam int ADDR_W      = 16;
	localparam int STORE_DEPTH = 1 << ADDR_W;
	localparam int RAW_W       = 8;
	localparam int COORD_W     = 17;
	localparam int HV_W        = 21;

	// scaled blend after alignment to 16 fraction bits: at most 255 * 2^16
	localparam int T_W         = 24;
	// divide by ten: floor(t * RECIP / 2^RECIP_SH), exact for t < 2^26
	localparam int RECIP_W     = 24;
	localparam int RECIP_SH    = 27;
	localparam logic [RECIP_W-1:0] RECIP = 24'd13421773;
	localparam logic [HV_W-1:0] HV_MAX = 21'd1671168;

	// command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH = 1'b1;

	localparam logic [CFG_DATA_W-1:0] GRID_SIZE_RST = 9'd256;

	// request bundle to the height store
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [RAW_W-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} hbs_store_req_t;

endpackage

`default_nettype wire

@@ design/hbs_store.sv @@
// ----------------------------------------------------------------------------
// hbs_store: raw height store
// Single-port-write, single-port-read synchronous memory, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_store
	import hbs_pkg::*;
(
	input  wire logic           clk,
	input  wire hbs_store_req_t req,
	output logic [RAW_W-1:0]    rdata
);

	logic [RAW_W-1:0] mem [STORE_DEPTH];
	logic [RAW_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ design/heightmap_bilinear_sampler_top.sv @@
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler_top: bilinear height sampler over a raw grid
// Loads 8-bit raw heights into a store and answers Q.8 point queries with
// the blended height divided by ten, in Q.16.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | dir | moves
//  --------+-------------------------------------------+-----+---------------
//  in      | in_valid/in_ready, cmd, cell_index,       | in  | load or query
//          | raw_height, query_x, query_z              |     | word
//  out     | out_valid/out_ready, height_value,        | out | result word
//          | in_range                                  |     | (queries only)
//  cfg     | cfg_we, cfg_index, cfg_data               | in  | register write
//
//  A load word is written to the store at the accepting edge.
//  An in-range query blocks new input until its result is registered: the store
//  has one read port, so the four neighbours are fetched one after another and
//  blended by multiply-accumulate steps, then scaled by a reciprocal multiply.
//  An out-of-range query skips the fetch. The result sits in an output register;
//  a stalled out channel holds the sequencer in its last step only.
//  Reset clears control state and sets both grid sizes to 256; the store is
//  not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_bilinear_sampler_top
	import hbs_pkg::*;
#(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_DEPTH = 256,
	parameter int FRAC_BITS = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  cmd,
	input  wire logic [ADDR_W-1:0]     cell_index,
	input  wire logic [RAW_W-1:0]      raw_height,
	input  wire logic signed [COORD_W-1:0] query_x,
	input  wire logic signed [COORD_W-1:0] query_z,

	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [HV_W-1:0]            height_value,
	output logic                       in_range,

	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// widths that follow from the parameters
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int DW     = $clog2(MAX_DEPTH + 1);
	localparam int GW     = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
	localparam int GD     = (DW > CFG_DATA_W) ? DW : CFG_DATA_W;
	localparam int UC_W   = COORD_W - 1;             // magnitude bits of a coordinate
	localparam int IW     = UC_W - FRAC_BITS;
	localparam int IXW    = (IW > 0) ? IW : 1;
	localparam int LX_W   = WW + FRAC_BITS;
	localparam int LZ_W   = DW + FRAC_BITS;
	localparam int CX_W   = (LX_W > UC_W) ? LX_W : UC_W;
	localparam int CZ_W   = (LZ_W > UC_W) ? LZ_W : UC_W;
	localparam int WT_W   = FRAC_BITS + 1;
	localparam int ROW_W  = RAW_W + FRAC_BITS;
	localparam int TOT_W  = RAW_W + 2 * FRAC_BITS;
	localparam int EXT_W  = TOT_W + 16;
	localparam int PROD_W = T_W + RECIP_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BASE,
		S_RD0,
		S_MAC0,
		S_MAC1,
		S_ROW0,
		S_MAC2,
		S_MAC3,
		S_ROW1,
		S_SCALE,
		S_DONE
	} hbs_state_t;

	hbs_state_t state_q;

	logic [CFG_DATA_W-1:0] grid_width_q;
	logic [CFG_DATA_W-1:0] grid_depth_q;

	logic                  oor_q;
	logic                  out_valid_q;
	logic [HV_W-1:0]       height_value_q;
	logic                  in_range_q;

	// datapath registers
	logic [IXW-1:0]        ix_q, iz_q;
	logic [FRAC_BITS-1:0]  fx_q, fz_q;
	logic [WW-1:0]         w_q;
	logic [ADDR_W-1:0]     base_q;
	logic [ROW_W-1:0]      row_q;
	logic [TOT_W-1:0]      tot_q;
	logic [PROD_W-1:0]     prod_q;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= GRID_SIZE_RST;
			grid_depth_q <= GRID_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_WIDTH: grid_width_q <= cfg_data;
				REG_GRID_DEPTH: grid_depth_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sizes saturated to [2, MAX]
	logic [GW-1:0] w_ext;
	logic [GD-1:0] d_ext;
	logic [WW-1:0] w_cl;
	logic [DW-1:0] d_cl;

	always_comb begin
		w_ext = GW'(grid_width_q);
		d_ext = GD'(grid_depth_q);
		if (w_ext < GW'(2)) begin
			w_cl = WW'(2);
		end else if (w_ext > GW'(MAX_WIDTH)) begin
			w_cl = WW'(MAX_WIDTH);
		end else begin
			w_cl = WW'(w_ext);
		end
		if (d_ext < GD'(2)) begin
			d_cl = DW'(2);
		end else if (d_ext > GD'(MAX_DEPTH)) begin
			d_cl = DW'(MAX_DEPTH);
		end else begin
			d_cl = DW'(d_ext);
		end
	end

	// ---------------------------------------------------------- range check
	logic [UC_W-1:0] x_u, z_u;
	logic [LX_W-1:0] lim_x;
	logic [LZ_W-1:0] lim_z;
	logic            q_in_range;

	assign x_u   = query_x[UC_W-1:0];
	assign z_u   = query_z[UC_W-1:0];
	// (size - 1) << FRAC_BITS
	assign lim_x = {w_cl - WW'(1), {FRAC_BITS{1'b0}}};
	assign lim_z = {d_cl - DW'(1), {FRAC_BITS{1'b0}}};
	assign q_in_range = !query_x[COORD_W-1] && !query_z[COORD_W-1] &&
		(CX_W'(x_u) < CX_W'(lim_x)) && (CZ_W'(z_u) < CZ_W'(lim_z));

	// ---------------------------------------------------------------- store
	hbs_store_req_t  st_req;
	logic [RAW_W-1:0] st_rdata;
	logic            in_acc;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;

	always_comb begin
		st_req.we    = in_acc && (cmd == CMD_LOAD);
		st_req.waddr = cell_index;
		st_req.wdata = raw_height;
		st_req.re    = 1'b0;
		st_req.raddr = base_q;
		unique case (state_q)
			S_RD0: begin
				st_req.re = 1'b1;
			end
			S_MAC0: begin
				st_req.re    = 1'b1;
				st_req.raddr = base_q + ADDR_W'(1);
			end
			S_ROW0: begin
				st_req.re    = 1'b1;
				st_req.raddr = base_q + ADDR_W'(w_q);
			end
			S_MAC2: begin
				st_req.re    = 1'b1;
				st_req.raddr = base_q + ADDR_W'(w_q) + ADDR_W'(1);
			end
			default: ;
		endcase
	end

	hbs_store u_store (
		.clk   (clk),
		.req   (st_req),
		.rdata (st_rdata)
	);

	// ------------------------------------------------------------- datapath
	logic [WT_W-1:0]  one_w;
	logic [WT_W-1:0]  wx0, wx1, wz0, wz1;
	logic [EXT_W-1:0] tot_ext;
	logic [T_W-1:0]   t_al;

	assign one_w = {1'b1, {FRAC_BITS{1'b0}}};
	assign wx0   = one_w - WT_W'(fx_q);
	assign wx1   = WT_W'(fx_q);
	assign wz0   = one_w - WT_W'(fz_q);
	assign wz1   = WT_W'(fz_q);
	// align the 2*FRAC_BITS blend to 16 fraction bits, truncating
	assign tot_ext = {tot_q, 16'b0};
	assign t_al    = tot_ext[EXT_W-1 -: T_W];

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ix_q <= IXW'(x_u >> FRAC_BITS);
			iz_q <= IXW'(z_u >> FRAC_BITS);
			fx_q <= FRAC_BITS'(x_u);
			fz_q <= FRAC_BITS'(z_u);
			w_q  <= w_cl;
		end
		unique case (state_q)
			S_BASE:  base_q <= ADDR_W'(iz_q * w_q) + ADDR_W'(ix_q);
			S_MAC0:  row_q  <= ROW_W'(st_rdata * wx0);
			S_MAC1:  row_q  <= row_q + ROW_W'(st_rdata * wx1);
			S_ROW0:  tot_q  <= TOT_W'(row_q * wz0);
			S_MAC2:  row_q  <= ROW_W'(st_rdata * wx0);
			S_MAC3:  row_q  <= row_q + ROW_W'(st_rdata * wx1);
			S_ROW1:  tot_q  <= tot_q + TOT_W'(row_q * wz1);
			S_SCALE: prod_q <= PROD_W'(t_al * RECIP);
			default: ;
		endcase
	end

	// ------------------------------------------------------------ sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			oor_q          <= 1'b0;
			out_valid_q    <= 1'b0;
			height_value_q <= '0;
			in_range_q     <= 1'b0;
		end else begin
			// new result word, or the slot emptied by the sink
			if ((state_q == S_DONE) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && (cmd == CMD_QUERY)) begin
						oor_q   <= !q_in_range;
						state_q <= q_in_range ? S_BASE : S_DONE;
					end
				end
				S_BASE:  state_q <= S_RD0;
				S_RD0:   state_q <= S_MAC0;
				S_MAC0:  state_q <= S_MAC1;
				S_MAC1:  state_q <= S_ROW0;
				S_ROW0:  state_q <= S_MAC2;
				S_MAC2:  state_q <= S_MAC3;
				S_MAC3:  state_q <= S_ROW1;
				S_ROW1:  state_q <= S_SCALE;
				S_SCALE: state_q <= S_DONE;
				S_DONE: begin
					// output slot free or being emptied this cycle
					if (!out_valid_q || out_ready) begin
						height_value_q <= oor_q ? '0 : HV_W'(prod_q >> RECIP_SH);
						in_range_q     <= !oor_q;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign height_value = height_value_q;
	assign in_range     = in_range_q;

endmodule

`default_nettype wire

@@ design/hbs_checker.sv @@
// ----------------------------------------------------------------------------
// hbs_checker: port-level checks for the heightmap bilinear sampler
// Watches the top level's channels and flags result and flow slips.
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_checker
	import hbs_pkg::*;
(
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_ready,
	input wire logic                      cmd,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic [HV_W-1:0]           height_value,
	input wire logic                      in_range
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(height_value) && $stable(in_range))
		else $error("result word changed while stalled");

	// off-grid queries read as zero
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_range |-> height_value == '0)
		else $error("off-grid result not zero");

	// blended height never exceeds 255 / 10 in Q.16
	a_hv_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> height_value <= HV_MAX)
		else $error("height above full scale");

	// a load leaves the input side free in the next cycle
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == CMD_LOAD |=> in_ready)
		else $error("input blocked after a load");

	// a query leaves the input side busy in the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == CMD_QUERY |=> !in_ready)
		else $error("input free right after a query");

endmodule

bind heightmap_bilinear_sampler_top hbs_checker u_hbs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.cmd          (cmd),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.height_value (height_value),
	.in_range     (in_range)
);

`default_nettype wire
